// ===== hdl/hprc_pkg.sv =====
// Shared types and constants of the heading PID rudder controller.
// Holds the microcode ROM, the control and status structs and the register map.
// No dependencies.
package hprc_pkg;

	localparam int SCALE      = 128;
	localparam int HALF_TURN  = 180 * SCALE;
	localparam int FULL_TURN  = 360 * SCALE;
	localparam int QUOT_W     = 16;
	localparam int STEP_W     = 4;
	localparam int BEAR_W     = 16;
	localparam int ANGLE_W    = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_CEILING = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RUDDER_MIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RUDDER_MAX    = 3'd6;

	localparam logic [15:0]        RST_PROP_GAIN     = 16'd256;
	localparam logic [15:0]        RST_INTEG_GAIN    = 16'd25600;
	localparam logic [15:0]        RST_DERIV_GAIN    = 16'd128;
	localparam logic signed [15:0] RST_INTEG_FLOOR   = -16'sd23040;
	localparam logic signed [15:0] RST_INTEG_CEILING = 16'sd23040;
	localparam logic [14:0]        RST_RUDDER_MIN    = 15'd2560;
	localparam logic [14:0]        RST_RUDDER_MAX    = 15'd20480;

	// Datapath operations
	localparam logic [3:0] ALU_NOP     = 4'd0;
	localparam logic [3:0] ALU_LOAD    = 4'd1;
	localparam logic [3:0] ALU_INTEG   = 4'd2;
	localparam logic [3:0] ALU_ADDP    = 4'd3;
	localparam logic [3:0] ALU_SUBD    = 4'd4;
	localparam logic [3:0] ALU_CLAMP   = 4'd5;
	localparam logic [3:0] ALU_DIVINIT = 4'd6;
	localparam logic [3:0] ALU_RECIP   = 4'd7;
	localparam logic [3:0] ALU_EMIT    = 4'd8;

	// Multiplier operand selects
	localparam logic [1:0] MA_ERR   = 2'd0;
	localparam logic [1:0] MA_DMEAS = 2'd1;
	localparam logic [1:0] MA_SPAN  = 2'd2;
	localparam logic [1:0] MB_KP    = 2'd0;
	localparam logic [1:0] MB_KI    = 2'd1;
	localparam logic [1:0] MB_KD    = 2'd2;
	localparam logic [1:0] MB_RANGE = 2'd3;

	// Sequencing conditions
	localparam logic [2:0] COND_NEXT = 3'd0;
	localparam logic [2:0] COND_IN   = 3'd1;
	localparam logic [2:0] COND_OUT  = 3'd3;
	localparam logic [2:0] COND_JUMP = 3'd4;

	// Program addresses
	localparam logic [STEP_W-1:0] ST_TAKE    = 4'd0;
	localparam logic [STEP_W-1:0] ST_IMUL    = 4'd1;
	localparam logic [STEP_W-1:0] ST_INTEG   = 4'd2;
	localparam logic [STEP_W-1:0] ST_PROP    = 4'd3;
	localparam logic [STEP_W-1:0] ST_DERIV   = 4'd4;
	localparam logic [STEP_W-1:0] ST_CLAMP   = 4'd5;
	localparam logic [STEP_W-1:0] ST_MAP     = 4'd6;
	localparam logic [STEP_W-1:0] ST_DIVINIT = 4'd7;
	localparam logic [STEP_W-1:0] ST_DIV     = 4'd8;
	localparam logic [STEP_W-1:0] ST_EMIT    = 4'd9;

	typedef struct packed {
		logic [3:0]        alu;
		logic              mul_en;
		logic [1:0]        ma;
		logic [1:0]        mb;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} cw_t;

	typedef struct packed {
		logic fire;
		cw_t  cw;
	} seq_ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [15:0]        prop_gain;
		logic [15:0]        integ_gain;
		logic [15:0]        deriv_gain;
		logic signed [15:0] integ_floor;
		logic signed [15:0] integ_ceiling;
		logic [14:0]        rudder_min;
		logic [14:0]        rudder_max;
	} cfg_t;

	function automatic cw_t mk_cw(input logic [3:0] alu, input logic mul_en,
			input logic [1:0] ma, input logic [1:0] mb,
			input logic [2:0] cond, input logic [STEP_W-1:0] target);
		return '{alu: alu, mul_en: mul_en, ma: ma, mb: mb, cond: cond, target: target};
	endfunction

	// Microcode ROM: one control word per step.
	function automatic cw_t ucode(input logic [STEP_W-1:0] step);
		cw_t w;
		case (step)
			ST_TAKE:    w = mk_cw(ALU_LOAD,    1'b0, MA_ERR,   MB_KP,    COND_IN,   ST_TAKE);
			ST_IMUL:    w = mk_cw(ALU_NOP,     1'b1, MA_ERR,   MB_KI,    COND_NEXT, ST_TAKE);
			ST_INTEG:   w = mk_cw(ALU_INTEG,   1'b1, MA_ERR,   MB_KP,    COND_NEXT, ST_TAKE);
			ST_PROP:    w = mk_cw(ALU_ADDP,    1'b1, MA_DMEAS, MB_KD,    COND_NEXT, ST_TAKE);
			ST_DERIV:   w = mk_cw(ALU_SUBD,    1'b0, MA_ERR,   MB_KP,    COND_NEXT, ST_TAKE);
			ST_CLAMP:   w = mk_cw(ALU_CLAMP,   1'b0, MA_ERR,   MB_KP,    COND_NEXT, ST_TAKE);
			ST_MAP:     w = mk_cw(ALU_NOP,     1'b1, MA_SPAN,  MB_RANGE, COND_NEXT, ST_TAKE);
			ST_DIVINIT: w = mk_cw(ALU_DIVINIT, 1'b0, MA_ERR,   MB_KP,    COND_NEXT, ST_TAKE);
			ST_DIV:     w = mk_cw(ALU_RECIP,   1'b0, MA_ERR,   MB_KP,    COND_NEXT, ST_TAKE);
			ST_EMIT:    w = mk_cw(ALU_EMIT,    1'b0, MA_ERR,   MB_KP,    COND_OUT,  ST_TAKE);
			default:    w = mk_cw(ALU_NOP,     1'b0, MA_ERR,   MB_KP,    COND_JUMP, ST_TAKE);
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/hprc_in_if.sv =====
// Input channel of the heading PID rudder controller: one item per bearing pair.
// No dependencies.
interface hprc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] target_bearing;
	logic [15:0] measured_bearing;

	modport source (output valid, output target_bearing, output measured_bearing, input ready);
	modport sink (input valid, input target_bearing, input measured_bearing, output ready);
endinterface

// ===== hdl/hprc_out_if.sv =====
// Output channel of the heading PID rudder controller: one rudder command per item.
// No dependencies.
interface hprc_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] rudder_angle;

	modport source (output valid, output rudder_angle, input ready);
	modport sink (input valid, input rudder_angle, output ready);
endinterface

// ===== hdl/heading_pid_rudder_control_core.sv =====
// Heading PID rudder controller, top level: config registers, microcode sequencer
// and datapath. Depends on hprc_pkg, hprc_in_if, hprc_out_if, hprc_cfg, hprc_seq, hprc_dpath.
//
//   channel   dir  handshake        payload
//   bearing   in   valid / ready    target_bearing[15:0], measured_bearing[15:0]
//   rudder    out  valid / ready    rudder_angle[14:0]
//   cfg       in   cfg_we           cfg_index[2:0], cfg_wdata[15:0]
//
// One item at a time: a step to take it, seven microcode steps through
// the single shared 17x17 multiplier and accumulator, one step that divides by
// OUTPUT_LIMIT through a reciprocal multiply, and one to load the output register.
// Reset clears the sequencer, the integral and the last bearing; there is no clearing pass.
// With the output register still full and not being taken, the sequencer holds at its last step.
module heading_pid_rudder_control_core #(
	parameter int OUTPUT_LIMIT = 180
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hprc_in_if.sink                         bearing,
	hprc_out_if.source                      rudder,
	input  logic                            cfg_we,
	input  logic [hprc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hprc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hprc_pkg::*;

	cfg_t     cfg;
	seq_ctl_t ctl;
	dp_stat_t stat;
	logic     seq_in_ready;
	logic     dp_out_free;

	hprc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	assign stat = '{in_valid: bearing.valid, out_free: dp_out_free};

	hprc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.ctl      (ctl),
		.in_ready (seq_in_ready)
	);

	hprc_dpath #(
		.OUTPUT_LIMIT (OUTPUT_LIMIT)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.cfg              (cfg),
		.target_bearing   (bearing.target_bearing),
		.measured_bearing (bearing.measured_bearing),
		.out_ready        (rudder.ready),
		.out_valid        (rudder.valid),
		.out_free         (dp_out_free),
		.rudder_angle     (rudder.rudder_angle)
	);

	assign bearing.ready = seq_in_ready;
endmodule

// ===== hdl/hprc_cfg.sv =====
// Configuration register file: gains, integral clamps and rudder limits.
// Depends on hprc_pkg.
module hprc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [hprc_pkg::CFG_IDX_W-1:0]  index,
	input  logic [hprc_pkg::CFG_DATA_W-1:0] wdata,
	output hprc_pkg::cfg_t                 cfg
);
	import hprc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= RST_PROP_GAIN;
			cfg_q.integ_gain    <= RST_INTEG_GAIN;
			cfg_q.deriv_gain    <= RST_DERIV_GAIN;
			cfg_q.integ_floor   <= RST_INTEG_FLOOR;
			cfg_q.integ_ceiling <= RST_INTEG_CEILING;
			cfg_q.rudder_min    <= RST_RUDDER_MIN;
			cfg_q.rudder_max    <= RST_RUDDER_MAX;
		end else if (we) begin
			case (index)
				REG_PROP_GAIN:     cfg_q.prop_gain     <= wdata;
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= wdata;
				REG_DERIV_GAIN:    cfg_q.deriv_gain    <= wdata;
				REG_INTEG_FLOOR:   cfg_q.integ_floor   <= $signed(wdata);
				REG_INTEG_CEILING: cfg_q.integ_ceiling <= $signed(wdata);
				REG_RUDDER_MIN:    cfg_q.rudder_min    <= wdata[14:0];
				REG_RUDDER_MAX:    cfg_q.rudder_max    <= wdata[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hdl/hprc_seq.sv =====
// Microcode sequencer: step counter and jump logic over the ROM.
// Depends on hprc_pkg.
module hprc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  hprc_pkg::dp_stat_t  stat,
	output hprc_pkg::seq_ctl_t  ctl,
	output logic                in_ready
);
	import hprc_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nx;
	cw_t               cw;
	logic              fire;

	assign cw = ucode(step_q);

	always_comb begin
		case (cw.cond)
			COND_IN:   fire = stat.in_valid;
			COND_OUT:  fire = stat.out_free;
			default:   fire = 1'b1;
		endcase
	end

	always_comb begin
		case (cw.cond)
			COND_IN:   step_nx = stat.in_valid ? step_q + 1'b1 : step_q;
			COND_OUT:  step_nx = stat.out_free ? cw.target : step_q;
			COND_JUMP: step_nx = cw.target;
			default:   step_nx = step_q + 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_TAKE;
		end else begin
			step_q <= step_nx;
		end
	end

	assign ctl      = '{fire: fire, cw: cw};
	assign in_ready = (cw.cond == COND_IN);
endmodule

// ===== hdl/hprc_dpath.sv =====
// Datapath: error fold, shared 17x17 multiplier, accumulator with clamps,
// reciprocal multiply for the rudder map, and the output register. Depends on hprc_pkg.
module hprc_dpath #(
	parameter int OUTPUT_LIMIT = 180
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hprc_pkg::seq_ctl_t          ctl,
	input  hprc_pkg::cfg_t              cfg,
	input  logic [hprc_pkg::BEAR_W-1:0] target_bearing,
	input  logic [hprc_pkg::BEAR_W-1:0] measured_bearing,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        out_free,
	output logic [hprc_pkg::ANGLE_W-1:0] rudder_angle
);
	import hprc_pkg::*;

	localparam int LIM      = OUTPUT_LIMIT * SCALE;
	localparam int SPAN_W   = $clog2(2 * LIM + 1);
	localparam int DIV_W    = QUOT_W + $clog2(OUTPUT_LIMIT + 1);
	localparam int RCP_SH   = DIV_W + $clog2(OUTPUT_LIMIT);
	localparam int RCP_W    = DIV_W + 1;
	localparam int QPROD_W  = DIV_W + RCP_W;
	localparam int OPD_W    = 17;
	localparam int PROD_W   = 2 * OPD_W;
	localparam int RND_W    = PROD_W - 8;
	localparam int ACC_W    = 27;
	localparam int RND_HALF = 128;
	localparam int QOFS     = 1 << (QUOT_W - 1);
	// Reciprocal of OUTPUT_LIMIT rounded up; exact floor division for any dividend of DIV_W bits.
	localparam logic [RCP_W-1:0] RCP_MUL =
		RCP_W'(((longint'(1) << RCP_SH) + longint'(OUTPUT_LIMIT) - 1) / longint'(OUTPUT_LIMIT));

	function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(RND_HALF);
		return $signed(t[PROD_W-1:8]);
	endfunction

	// State kept across items
	logic signed [15:0]       integ_q;
	logic [BEAR_W-1:0]        last_q;
	logic                     ovalid_q;

	// Per-item working registers
	logic signed [OPD_W-1:0]  err_q;
	logic signed [OPD_W-1:0]  dmeas_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [SPAN_W-1:0]        span_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DIV_W-1:0]         dvd_q;
	logic [QUOT_W-1:0]        quot_q;
	logic [ANGLE_W-1:0]       rud_q;

	logic signed [17:0]       raw_err;
	logic signed [17:0]       fold_err;
	logic signed [OPD_W-1:0]  dmeas_c;
	logic signed [OPD_W-1:0]  mul_a;
	logic signed [OPD_W-1:0]  mul_b;
	logic signed [OPD_W-1:0]  range_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [ACC_W-1:0]  p_ext;
	logic signed [ACC_W-1:0]  integ_sum;
	logic signed [15:0]       integ_nx;
	logic signed [ACC_W-1:0]  lim_s;
	logic signed [ACC_W-1:0]  acc_clamp;
	logic signed [PROD_W-1:0] map_x;
	logic signed [PROD_W-1:0] map_y;
	logic signed [PROD_W-1:0] map_yy;
	logic [QPROD_W-1:0]       qprod_c;
	logic                     do_alu;

	assign do_alu = ctl.fire;

	always_comb begin
		raw_err = $signed({2'b00, target_bearing}) - $signed({2'b00, measured_bearing});
		// The error is folded once only; bearings past 360 may leave it outside +-180.
		if (raw_err > 18'(HALF_TURN)) begin
			fold_err = raw_err - 18'(FULL_TURN);
		end else if (raw_err < -18'(HALF_TURN)) begin
			fold_err = raw_err + 18'(FULL_TURN);
		end else begin
			fold_err = raw_err;
		end
		dmeas_c = $signed({1'b0, measured_bearing}) - $signed({1'b0, last_q});
	end

	assign range_c = $signed({2'b00, cfg.rudder_max}) - $signed({2'b00, cfg.rudder_min});

	always_comb begin
		case (ctl.cw.ma)
			MA_ERR:   mul_a = err_q;
			MA_DMEAS: mul_a = dmeas_q;
			MA_SPAN:  mul_a = $signed(OPD_W'(span_q));
			default:  mul_a = err_q;
		endcase
		case (ctl.cw.mb)
			MB_KP:    mul_b = $signed({1'b0, cfg.prop_gain});
			MB_KI:    mul_b = $signed({1'b0, cfg.integ_gain});
			MB_KD:    mul_b = $signed({1'b0, cfg.deriv_gain});
			MB_RANGE: mul_b = range_c;
			default:  mul_b = $signed({1'b0, cfg.prop_gain});
		endcase
	end

	assign prod_c = mul_a * mul_b;
	assign p_ext  = ACC_W'(rnd(prod_q));

	always_comb begin
		integ_sum = ACC_W'(integ_q) + p_ext;
		// Ceiling is tested first so that a floor above the ceiling still gives a bound.
		if (integ_sum > ACC_W'(cfg.integ_ceiling)) begin
			integ_nx = cfg.integ_ceiling;
		end else if (integ_sum < ACC_W'(cfg.integ_floor)) begin
			integ_nx = cfg.integ_floor;
		end else begin
			integ_nx = integ_sum[15:0];
		end
	end

	assign lim_s = ACC_W'(LIM);

	always_comb begin
		if (acc_q > lim_s) begin
			acc_clamp = lim_s;
		end else if (acc_q < -lim_s) begin
			acc_clamp = -lim_s;
		end else begin
			acc_clamp = acc_q;
		end
	end

	// Rudder map: floor((num + L*128) / (L*256)) is a shift by 8 and a divide by L.
	// The offset keeps the dividend positive; it vanishes in the 15-bit result.
	always_comb begin
		map_x  = prod_q + PROD_W'(LIM);
		map_y  = map_x >>> 8;
		map_yy = map_y + PROD_W'(QOFS * OUTPUT_LIMIT);
	end

	// The divide by L is a multiply by its reciprocal and a shift.
	assign qprod_c = dvd_q * RCP_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			last_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (do_alu && ctl.cw.alu == ALU_LOAD) begin
				last_q <= measured_bearing;
			end
			if (do_alu && ctl.cw.alu == ALU_INTEG) begin
				integ_q <= integ_nx;
			end
			if (do_alu && ctl.cw.alu == ALU_EMIT) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_alu && ctl.cw.mul_en) begin
			prod_q <= prod_c;
		end
		if (do_alu) begin
			case (ctl.cw.alu)
				ALU_LOAD: begin
					err_q   <= fold_err[OPD_W-1:0];
					dmeas_q <= dmeas_c;
				end
				ALU_INTEG:   acc_q <= ACC_W'(integ_nx);
				ALU_ADDP:    acc_q <= acc_q + p_ext;
				ALU_SUBD:    acc_q <= acc_q - p_ext;
				ALU_CLAMP:   span_q <= SPAN_W'(acc_clamp + lim_s);
				ALU_DIVINIT: dvd_q <= map_yy[DIV_W-1:0];
				ALU_RECIP:   quot_q <= qprod_c[RCP_SH +: QUOT_W];
				ALU_EMIT:    rud_q <= quot_q[ANGLE_W-1:0] + cfg.rudder_min;
				default: ;
			endcase
		end
	end

	assign out_valid    = ovalid_q;
	assign out_free     = !ovalid_q || out_ready;
	assign rudder_angle = rud_q;
endmodule

// ===== hdl/hprc_chk.sv =====
// Port-level checker for the heading PID rudder controller, bound to the top level.
// Depends on hprc_pkg.
module hprc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hprc_pkg::ANGLE_W-1:0]  rudder_angle
);
	import hprc_pkg::*;

	// A waiting result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rudder_angle))
		else $error("rudder result changed or dropped while stalled");

	// One item at a time: the block is busy right after taking one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after an item");

	// No fresh result appears in the cycle after an item is taken.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || $past(out_valid))
		else $error("result appeared one cycle after an item was taken");

	// Loading a result returns the sequencer to its input step.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("not ready for an item after a result was loaded");
endmodule

bind heading_pid_rudder_control_core hprc_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (bearing.valid),
	.in_ready     (bearing.ready),
	.out_valid    (rudder.valid),
	.out_ready    (rudder.ready),
	.rudder_angle (rudder.rudder_angle)
);
